@@ sv/ipp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the IP address text parser.
package ipp_pkg;

   // Number of 16-bit groups in an IPv6 address.
   localparam int unsigned NUM_GROUPS = 8;

   // Character codes that the parser reacts to.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // Code returned by hex_of for a character that is not a hex digit.
   localparam logic [4:0] HEX_NONE = 5'd16;

   // Parse phase codes.
   typedef enum logic [2:0] {
      PH_BEGIN       = 3'd0,
      PH_LEAD        = 3'd1,
      PH_AFTER_GAP   = 3'd2,
      PH_AFTER_COLON = 3'd3,
      PH_GROUP       = 3'd4,
      PH_DOTTED      = 3'd5
   } phase_type;

   typedef logic [15:0] group_type;

   // Snapshot of the parse state at the terminator, handed to the finishing stage.
   typedef struct packed {
      logic                           failed;
      logic                           family;
      phase_type                      phase;
      logic [2:0]                     digits_seen;
      logic [1:0]                     octet_index;
      logic [7:0]                     decimal_value;
      logic [31:0]                    dotted_value;
      logic [3:0]                     group_count;
      logic                           gap_seen;
      logic [3:0]                     gap_position;
      group_type                      hex_value;
      logic [NUM_GROUPS-1:0][15:0]    groups;
   } fin_job_type;

   // Hex digit value of a character, or HEX_NONE when it is not a hex digit.
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [4:0] v;
      v = HEX_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

@@ sv/ipp_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts characters, tracks the parse state and posts a job at each terminator.
module ipp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_code,
   input  logic                req_is_ipv6,
   output logic                job_valid,
   output ipp_pkg::fin_job_type job,
   input  logic                job_full
);
   import ipp_pkg::*;

   // Parse state registers.
   logic                 in_string_ff,    in_string_in;
   logic                 family_ff,       family_in;
   logic                 failed_ff,       failed_in;
   group_type            groups_ff [NUM_GROUPS];
   logic [3:0]           group_count_ff,  group_count_in;
   logic [3:0]           gap_position_ff, gap_position_in;
   logic                 gap_seen_ff,     gap_seen_in;
   group_type            hex_value_ff,    hex_value_in;
   logic [2:0]           digits_seen_ff,  digits_seen_in;
   logic [7:0]           decimal_value_ff, decimal_value_in;
   logic                 decimal_bad_ff,  decimal_bad_in;
   logic [1:0]           octet_index_ff,  octet_index_in;
   logic [31:0]          dotted_value_ff, dotted_value_in;
   phase_type            phase_ff,        phase_in;

   // State as seen by the current character (cleared at the start of a string).
   logic                 b_family;
   logic                 b_failed;
   logic [3:0]           b_group_count;
   logic [3:0]           b_gap_position;
   logic                 b_gap_seen;
   group_type            b_hex_value;
   logic [2:0]           b_digits_seen;
   logic [7:0]           b_decimal_value;
   logic                 b_decimal_bad;
   logic [1:0]           b_octet_index;
   logic [31:0]          b_dotted_value;
   phase_type            b_phase;

   logic                 accept;
   logic                 is_nul;
   logic                 group_wr;
   logic [4:0]           hex;
   logic                 is_hex;
   logic [11:0]          dec_grow;
   logic [11:0]          dot_grow;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;
   assign is_nul    = (req_char_code == CHAR_NUL);
   assign job_valid = accept && is_nul;

   // Base state: the first character of a string sees freshly cleared state.
   always_comb begin
      if (in_string_ff) begin
         b_family        = family_ff;
         b_failed        = failed_ff;
         b_group_count   = group_count_ff;
         b_gap_position  = gap_position_ff;
         b_gap_seen      = gap_seen_ff;
         b_hex_value     = hex_value_ff;
         b_digits_seen   = digits_seen_ff;
         b_decimal_value = decimal_value_ff;
         b_decimal_bad   = decimal_bad_ff;
         b_octet_index   = octet_index_ff;
         b_dotted_value  = dotted_value_ff;
         b_phase         = phase_ff;
      end else begin
         b_family        = req_is_ipv6;
         b_failed        = 1'b0;
         b_group_count   = '0;
         b_gap_position  = '0;
         b_gap_seen      = 1'b0;
         b_hex_value     = '0;
         b_digits_seen   = '0;
         b_decimal_value = '0;
         b_decimal_bad   = 1'b0;
         b_octet_index   = '0;
         b_dotted_value  = '0;
         b_phase         = req_is_ipv6 ? PH_BEGIN : PH_DOTTED;
      end
   end

   // Snapshot handed to the finishing stage at the terminator.
   always_comb begin
      job.failed        = b_failed;
      job.family        = b_family;
      job.phase         = b_phase;
      job.digits_seen   = b_digits_seen;
      job.octet_index   = b_octet_index;
      job.decimal_value = b_decimal_value;
      job.dotted_value  = b_dotted_value;
      job.group_count   = b_group_count;
      job.gap_seen      = b_gap_seen;
      job.gap_position  = b_gap_position;
      job.hex_value     = b_hex_value;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         job.groups[i] = groups_ff[i];
      end
   end

   assign hex      = hex_of(req_char_code);
   assign is_hex   = (hex != HEX_NONE);
   assign dec_grow = 12'(b_decimal_value) * 12'd10 + 12'(hex[3:0]);
   assign dot_grow = 12'(b_decimal_value) * 12'd10 + 12'(req_char_code - 8'h30);

   // Per-character state update.
   always_comb begin
      in_string_in     = 1'b1;
      family_in        = b_family;
      failed_in        = b_failed;
      group_count_in   = b_group_count;
      gap_position_in  = b_gap_position;
      gap_seen_in      = b_gap_seen;
      hex_value_in     = b_hex_value;
      digits_seen_in   = b_digits_seen;
      decimal_value_in = b_decimal_value;
      decimal_bad_in   = b_decimal_bad;
      octet_index_in   = b_octet_index;
      dotted_value_in  = b_dotted_value;
      phase_in         = b_phase;
      group_wr         = 1'b0;

      if (is_nul) begin
         in_string_in = 1'b0;
      end else if (!b_failed) begin
         unique case (b_phase)
            PH_DOTTED: begin
               if (req_char_code >= 8'h30 && req_char_code <= 8'h39) begin
                  if (dot_grow > 12'd255) begin
                     failed_in = 1'b1;
                  end else begin
                     decimal_value_in = dot_grow[7:0];
                     digits_seen_in   = 3'd1;
                  end
               end else if (req_char_code == CHAR_DOT) begin
                  if (b_digits_seen == 3'd0 || b_octet_index == 2'd3) begin
                     failed_in = 1'b1;
                  end else begin
                     dotted_value_in  = {b_dotted_value[23:0], b_decimal_value};
                     octet_index_in   = b_octet_index + 2'd1;
                     digits_seen_in   = 3'd0;
                     decimal_value_in = '0;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_BEGIN, PH_LEAD, PH_AFTER_GAP, PH_AFTER_COLON: begin
               if (req_char_code == CHAR_COLON &&
                   (b_phase == PH_LEAD || b_phase == PH_AFTER_COLON)) begin
                  // Opening the one permitted gap.
                  if (b_gap_seen) begin
                     failed_in = 1'b1;
                  end else begin
                     gap_seen_in     = 1'b1;
                     gap_position_in = b_group_count;
                     phase_in        = PH_AFTER_GAP;
                  end
               end else if (req_char_code == CHAR_COLON && b_phase == PH_BEGIN) begin
                  phase_in = PH_LEAD;
               end else if (is_hex && b_phase != PH_LEAD) begin
                  // Starting a new group with its first digit.
                  if (b_group_count >= 4'd8) begin
                     failed_in = 1'b1;
                  end else begin
                     hex_value_in     = 16'(hex[3:0]);
                     digits_seen_in   = 3'd1;
                     decimal_bad_in   = (hex > 5'd9);
                     decimal_value_in = (hex > 5'd9) ? 8'd0 : 8'(hex[3:0]);
                     phase_in         = PH_GROUP;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_GROUP: begin
               if (is_hex) begin
                  if (b_digits_seen >= 3'd4) begin
                     failed_in = 1'b1;
                  end else begin
                     hex_value_in   = {b_hex_value[11:0], hex[3:0]};
                     digits_seen_in = b_digits_seen + 3'd1;
                     if (hex > 5'd9) begin
                        decimal_bad_in = 1'b1;
                     end else if (!b_decimal_bad) begin
                        if (dec_grow > 12'd255) begin
                           decimal_bad_in = 1'b1;
                        end else begin
                           decimal_value_in = dec_grow[7:0];
                        end
                     end
                  end
               end else if (req_char_code == CHAR_DOT) begin
                  // The group turns out to be the first octet of an IPv4 tail.
                  if (b_group_count > 4'd6 || b_decimal_bad) begin
                     failed_in = 1'b1;
                  end else begin
                     dotted_value_in  = 32'(b_decimal_value);
                     octet_index_in   = 2'd1;
                     digits_seen_in   = 3'd0;
                     decimal_value_in = '0;
                     phase_in         = PH_DOTTED;
                  end
               end else if (req_char_code == CHAR_COLON) begin
                  group_wr       = 1'b1;
                  group_count_in = b_group_count + 4'd1;
                  phase_in       = PH_AFTER_COLON;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff     <= 1'b0;
         family_ff        <= 1'b0;
         failed_ff        <= 1'b0;
         group_count_ff   <= '0;
         gap_position_ff  <= '0;
         gap_seen_ff      <= 1'b0;
         hex_value_ff     <= '0;
         digits_seen_ff   <= '0;
         decimal_value_ff <= '0;
         decimal_bad_ff   <= 1'b0;
         octet_index_ff   <= '0;
         dotted_value_ff  <= '0;
         phase_ff         <= PH_BEGIN;
      end else if (accept) begin
         in_string_ff     <= in_string_in;
         family_ff        <= family_in;
         failed_ff        <= failed_in;
         group_count_ff   <= group_count_in;
         gap_position_ff  <= gap_position_in;
         gap_seen_ff      <= gap_seen_in;
         hex_value_ff     <= hex_value_in;
         digits_seen_ff   <= digits_seen_in;
         decimal_value_ff <= decimal_value_in;
         decimal_bad_ff   <= decimal_bad_in;
         octet_index_ff   <= octet_index_in;
         dotted_value_ff  <= dotted_value_in;
         phase_ff         <= phase_in;
      end
   end

   // Group store: an entry is only read once it has been written in this string.
   always_ff @(posedge clock) begin
      if (accept && group_wr) begin
         groups_ff[b_group_count[2:0]] <= b_hex_value;
      end
   end

   // A closed group can never push the count past eight.
   a_group_count_bound: assert property (@(posedge clock) disable iff (reset)
      group_count_ff <= 4'd8)
      else $error("group count above eight");

   // Once a string has failed, the parse state stays put until the terminator.
   a_failed_freezes: assert property (@(posedge clock) disable iff (reset)
      accept && in_string_ff && failed_ff && !is_nul |=>
         failed_ff && phase_ff == $past(phase_ff) && group_count_ff == $past(group_count_ff))
      else $error("state changed after a failure");

   // A terminator always closes the string.
   a_nul_ends_string: assert property (@(posedge clock) disable iff (reset)
      accept && is_nul |=> !in_string_ff)
      else $error("string still open after its terminator");

endmodule

@@ sv/ipp_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the character front end and the finishing stage.
module ipp_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ipp_pkg::fin_job_type push_data,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ipp_pkg::fin_job_type pop_data
);
   import ipp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   fin_job_type       entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   // The front end must hold a terminator back while the queue is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && full))
      else $error("job pushed into a full queue");

   // A full queue always offers a job to the back end.
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      full |-> pop_valid)
      else $error("queue full and empty at once");

endmodule

@@ sv/ipp_back.sv @@
`timescale 1ns / 1ps
// Back end: checks the finished parse, expands the gap and holds the result register.
module ipp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  ipp_pkg::fin_job_type job,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_ok,
   output logic [63:0]         rsp_addr_high,
   output logic [63:0]         rsp_addr_low
);
   import ipp_pkg::*;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff;
   logic [63:0]   rsp_addr_high_ff;
   logic [63:0]   rsp_addr_low_ff;

   logic          load;
   logic          good;
   logic          shape_ok;
   logic [31:0]   v4;
   logic [3:0]    count;
   logic [3:0]    missing;
   logic [3:0]    gap_end;
   group_type     w [NUM_GROUPS];
   group_type     r [NUM_GROUPS];
   logic [63:0]   hi;
   logic [63:0]   lo;

   assign job_ready = !rsp_valid_ff || rsp_ready;
   assign load      = job_valid && job_ready;

   // Final validity check and reassembly of the address.
   always_comb begin
      good     = 1'b0;
      shape_ok = 1'b1;
      hi       = '0;
      lo       = '0;
      v4       = {job.dotted_value[23:0], job.decimal_value};
      count    = job.group_count;
      missing  = '0;
      gap_end  = '0;
      for (int i = 0; i < NUM_GROUPS; i++) begin
         w[i] = job.groups[i];
         r[i] = '0;
      end

      if (!job.failed) begin
         if (!job.family) begin
            if (job.phase == PH_DOTTED && job.digits_seen != 3'd0 &&
                job.octet_index == 2'd3) begin
               good = 1'b1;
               lo   = {32'd0, v4};
            end
         end else begin
            // Close the open group or the IPv4 tail.
            if (job.phase == PH_GROUP) begin
               if (count >= 4'd8) begin
                  shape_ok = 1'b0;
               end else begin
                  w[count[2:0]] = job.hex_value;
                  count         = count + 4'd1;
               end
            end else if (job.phase == PH_DOTTED) begin
               if (job.digits_seen == 3'd0 || job.octet_index != 2'd3 || count > 4'd6) begin
                  shape_ok = 1'b0;
               end else begin
                  w[count[2:0]]        = v4[31:16];
                  w[count[2:0] + 3'd1] = v4[15:0];
                  count                = count + 4'd2;
               end
            end else if (job.phase != PH_AFTER_GAP) begin
               shape_ok = 1'b0;
            end

            // Fill the gap with zero groups, or demand all eight groups.
            if (shape_ok) begin
               if (job.gap_seen) begin
                  if (count < 4'd8 && job.gap_position <= count) begin
                     missing = 4'd8 - count;
                     gap_end = job.gap_position + missing;
                     for (int i = 0; i < NUM_GROUPS; i++) begin
                        if (4'(i) < job.gap_position) begin
                           r[i] = w[i];
                        end else if (4'(i) < gap_end) begin
                           r[i] = '0;
                        end else begin
                           r[i] = w[3'(4'(i) - missing)];
                        end
                     end
                     good = 1'b1;
                  end
               end else if (count == 4'd8) begin
                  for (int i = 0; i < NUM_GROUPS; i++) begin
                     r[i] = w[i];
                  end
                  good = 1'b1;
               end
            end
            if (good) begin
               hi = {r[0], r[1], r[2], r[3]};
               lo = {r[4], r[5], r[6], r[7]};
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Result register: control cleared by reset, payload loaded with each job.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ok_ff        <= good;
         rsp_addr_high_ff <= hi;
         rsp_addr_low_ff  <= lo;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_addr_high = rsp_addr_high_ff;
   assign rsp_addr_low  = rsp_addr_low_ff;

   // A rejected string reports an all-zero address.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_addr_high_ff == '0 && rsp_addr_low_ff == '0)
      else $error("rejected string carries an address");

   // A job that failed during parsing always comes out rejected.
   a_failed_rejected: assert property (@(posedge clock) disable iff (reset)
      load && job.failed |=> rsp_valid_ff && !rsp_ok_ff)
      else $error("failed string reported as valid");

   // An IPv4 result never touches the upper half.
   a_ipv4_high_zero: assert property (@(posedge clock) disable iff (reset)
      load && !job.family |=> rsp_addr_high_ff == '0)
      else $error("IPv4 result with non-zero upper half");

endmodule

@@ sv/ip_address_text_parser.sv @@
`timescale 1ns / 1ps
// Top level of the streaming IPv4 / IPv6 address text parser.
//
//   Channel   Ports                                   Direction  Transfer
//   request   req_valid/ready, req_char_code, req_is_ipv6   in   one character
//   response  rsp_valid/ready, rsp_ok, rsp_addr_high/low    out  one result per zero byte
//
// One character is taken per cycle while the job queue has room; a terminator's result passes
// through the job queue and then the result register. The front end stalls only when the job
// queue (QUEUE_DEPTH entries) is full, which happens only while the response side holds off.
// Reset is synchronous and active high; it clears all control state and needs no clearing pass.
module ip_address_text_parser #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_char_code,
   input  logic          req_is_ipv6,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_ok,
   output logic [63:0]   rsp_addr_high,
   output logic [63:0]   rsp_addr_low
);
   import ipp_pkg::*;

   logic          push_valid;
   fin_job_type   push_data;
   logic          q_full;
   logic          pop_valid;
   logic          pop_ready;
   fin_job_type   pop_data;

   // Character parsing.
   ipp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_ipv6   (req_is_ipv6),
      .job_valid     (push_valid),
      .job           (push_data),
      .job_full      (q_full)
   );

   // Decoupling queue.
   ipp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Finishing and result register.
   ipp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (pop_valid),
      .job_ready     (pop_ready),
      .job           (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_addr_high (rsp_addr_high),
      .rsp_addr_low  (rsp_addr_low)
   );

endmodule

@@ dv/ip_address_text_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the streaming IPv4 / IPv6 address text parser.
module ip_address_text_parser_tb;
   import ipp_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef byte unsigned char_q_type[$];

   typedef struct packed {
      logic        ok;
      logic [63:0] hi;
      logic [63:0] lo;
   } parsed_addr_type;

   typedef struct {
      string           text;
      logic            v6;
      bit              fixed;
      parsed_addr_type want;
   } directed_row_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = CHAR_NUL;
   logic        req_is_ipv6   = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic        rsp_ok;
   logic [63:0] rsp_addr_high;
   logic [63:0] rsp_addr_low;

   // Parser state as the predictor keeps it.
   logic        in_str;
   logic        fam_v6;
   logic        pfail;
   group_type   grp [NUM_GROUPS];
   logic [3:0]  grp_cnt;
   logic [3:0]  gap_pos;
   logic        gap_on;
   logic [15:0] hex_acc;
   logic [2:0]  dig_cnt;
   logic [7:0]  dec_acc;
   logic        dec_bad;
   logic [1:0]  oct_idx;
   logic [31:0] dot_acc;
   phase_type   ph;

   parsed_addr_type  expected_addrs[$];
   directed_row_type directed_rows[$];
   int unsigned      mismatches    = 0;
   int unsigned      idle_cycles   = 0;
   int unsigned      chars_sent    = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      stall_pct     = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   ip_address_text_parser dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_ipv6   (req_is_ipv6),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_addr_high (rsp_addr_high),
      .rsp_addr_low  (rsp_addr_low)
   );

   // ------------------------------------------------------------------
   // Predictor of the parse state.
   // ------------------------------------------------------------------

   function automatic void clear_parser();
      in_str  = 1'b0;
      fam_v6  = 1'b0;
      pfail   = 1'b0;
      foreach (grp[i]) grp[i] = '0;
      grp_cnt = '0;
      gap_pos = '0;
      gap_on  = 1'b0;
      hex_acc = '0;
      dig_cnt = '0;
      dec_acc = '0;
      dec_bad = 1'b0;
      oct_idx = '0;
      dot_acc = '0;
      ph      = PH_BEGIN;
   endfunction

   function automatic int unsigned hex_digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return HEX_NONE;
   endfunction

   // A hex digit also feeds the decimal reading, in case the group turns out to
   // be the first octet of a dotted tail.
   function automatic void take_hex_digit(int unsigned h);
      int unsigned t;
      hex_acc = {hex_acc[11:0], 4'(h)};
      dig_cnt = dig_cnt + 3'd1;
      if (h > 9) begin
         dec_bad = 1'b1;
      end else if (!dec_bad) begin
         t = 32'(dec_acc) * 10 + h;
         if (t > 255) dec_bad = 1'b1;
         else dec_acc = 8'(t);
      end
   endfunction

   function automatic void begin_group(int unsigned h);
      if (grp_cnt >= NUM_GROUPS) begin
         pfail = 1'b1;
      end else begin
         hex_acc = '0;
         dig_cnt = '0;
         dec_acc = '0;
         dec_bad = 1'b0;
         take_hex_digit(h);
         ph = PH_GROUP;
      end
   endfunction

   function automatic void open_gap();
      if (gap_on) begin
         pfail = 1'b1;
      end else begin
         gap_on  = 1'b1;
         gap_pos = grp_cnt;
         ph      = PH_AFTER_GAP;
      end
   endfunction

   function automatic void take_dotted(logic [7:0] c);
      int unsigned t;
      if (c >= "0" && c <= "9") begin
         t = 32'(dec_acc) * 10 + (c - "0");
         if (t > 255) begin
            pfail = 1'b1;
         end else begin
            dec_acc = 8'(t);
            dig_cnt = 3'd1;
         end
      end else if (c == CHAR_DOT) begin
         if (dig_cnt == 0 || oct_idx >= 3) begin
            pfail = 1'b1;
         end else begin
            dot_acc = {dot_acc[23:0], dec_acc};
            oct_idx = oct_idx + 2'd1;
            dig_cnt = '0;
            dec_acc = '0;
         end
      end else begin
         pfail = 1'b1;
      end
   endfunction

   function automatic void feed_char(logic [7:0] c);
      int unsigned h;
      h = hex_digit_value(c);
      case (ph)
         PH_DOTTED: begin
            take_dotted(c);
         end
         PH_BEGIN: begin
            if (c == CHAR_COLON) ph = PH_LEAD;
            else if (h < HEX_NONE) begin_group(h);
            else pfail = 1'b1;
         end
         PH_LEAD: begin
            if (c == CHAR_COLON) open_gap();
            else pfail = 1'b1;
         end
         PH_AFTER_GAP: begin
            if (h < HEX_NONE) begin_group(h);
            else pfail = 1'b1;
         end
         PH_AFTER_COLON: begin
            if (c == CHAR_COLON) open_gap();
            else if (h < HEX_NONE) begin_group(h);
            else pfail = 1'b1;
         end
         PH_GROUP: begin
            if (h < HEX_NONE) begin
               if (dig_cnt >= 4) pfail = 1'b1;
               else take_hex_digit(h);
            end else if (c == CHAR_DOT) begin
               // The group just scanned becomes the first octet of a dotted tail.
               if (grp_cnt > 6 || dec_bad) begin
                  pfail = 1'b1;
               end else begin
                  dot_acc = {24'd0, dec_acc};
                  oct_idx = 2'd1;
                  dig_cnt = '0;
                  dec_acc = '0;
                  ph      = PH_DOTTED;
               end
            end else if (c == CHAR_COLON) begin
               grp[grp_cnt[2:0]] = hex_acc;
               grp_cnt = grp_cnt + 4'd1;
               ph = PH_AFTER_COLON;
            end else begin
               pfail = 1'b1;
            end
         end
         default: begin
            pfail = 1'b1;
         end
      endcase
   endfunction

   // Works out the address at the terminator, filling any gap with zero groups.
   function automatic parsed_addr_type assemble_address();
      parsed_addr_type res;
      group_type       w [NUM_GROUPS];
      group_type       r [NUM_GROUPS];
      logic [31:0]     v4;
      int unsigned     cnt;
      int unsigned     missing;
      int unsigned     gp;
      res = '0;
      if (pfail) return res;
      if (!fam_v6) begin
         if (ph != PH_DOTTED || dig_cnt == 0 || oct_idx != 3) return res;
         res.ok = 1'b1;
         res.lo = {32'd0, dot_acc[23:0], dec_acc};
         return res;
      end
      w   = grp;
      cnt = grp_cnt;
      if (ph == PH_GROUP) begin
         if (cnt >= NUM_GROUPS) return res;
         w[cnt] = hex_acc;
         cnt++;
      end else if (ph == PH_DOTTED) begin
         if (dig_cnt == 0 || oct_idx != 3 || cnt > 6) return res;
         v4 = {dot_acc[23:0], dec_acc};
         w[cnt]     = v4[31:16];
         w[cnt + 1] = v4[15:0];
         cnt += 2;
      end else if (ph != PH_AFTER_GAP) begin
         return res;
      end
      if (gap_on) begin
         gp = gap_pos;
         if (cnt >= NUM_GROUPS || gp > cnt) return res;
         missing = NUM_GROUPS - cnt;
         for (int i = 0; i < NUM_GROUPS; i++) begin
            if (i < gp) r[i] = w[i];
            else if (i < gp + missing) r[i] = '0;
            else r[i] = w[(i - missing) % NUM_GROUPS];
         end
      end else begin
         if (cnt != NUM_GROUPS) return res;
         r = w;
      end
      res.ok = 1'b1;
      res.hi = {r[0], r[1], r[2], r[3]};
      res.lo = {r[4], r[5], r[6], r[7]};
      return res;
   endfunction

   // Advances the predictor by one character; returns 1 when a result is due.
   function automatic bit step_parser(input logic [7:0] c, input logic v6,
                                      output parsed_addr_type res);
      res = '0;
      if (!in_str) begin
         clear_parser();
         in_str = 1'b1;
         fam_v6 = v6;
         ph     = v6 ? PH_BEGIN : PH_DOTTED;
      end
      if (c == CHAR_NUL) begin
         res    = assemble_address();
         in_str = 1'b0;
         return 1'b1;
      end
      if (!pfail) feed_char(c);
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Text generation.
   // ------------------------------------------------------------------

   function automatic char_q_type text_chars(string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic string dec_text(int unsigned v, int unsigned max_len);
      string s;
      s = $sformatf("%0d", v);
      while (s.len() < max_len && $urandom_range(3) == 0) s = {"0", s};
      return s;
   endfunction

   // Mostly in range and biased to the extremes; now and then too large.
   function automatic int unsigned pick_octet();
      if ($urandom_range(19) == 0) return $urandom_range(999, 256);
      case ($urandom_range(3))
         0: return 0;
         1: return 255;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic string ipv4_text(int unsigned first_len);
      string s;
      s = dec_text(pick_octet(), first_len);
      repeat (3) s = {s, ".", dec_text(pick_octet(), 5)};
      return s;
   endfunction

   function automatic byte unsigned noise_char();
      string pool;
      pool = "0123456789abcdefABCDEFgxz :.";
      if ($urandom_range(2) == 0) return 8'($urandom_range(255, 1));
      return pool[$urandom_range(pool.len() - 1)];
   endfunction

   // ------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------

   task automatic push_char(input logic [7:0] c, input logic v6, input bit fixed,
                            input parsed_addr_type fixed_res);
      parsed_addr_type got;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_is_ipv6   <= v6;
      do @(posedge clock); while (req_ready !== 1'b1);
      chars_sent++;
      if (step_parser(c, v6, got)) expected_addrs.push_back(fixed ? fixed_res : got);
   endtask

   // The family only matters on the first character, so later ones carry noise.
   task automatic send_text(input char_q_type chars, input logic v6, input bit fixed,
                            input parsed_addr_type fixed_res);
      foreach (chars[i]) begin
         push_char(chars[i], (i == 0) ? v6 : 1'($urandom_range(1)), fixed, fixed_res);
      end
      push_char(CHAR_NUL, (chars.size() == 0) ? v6 : 1'($urandom_range(1)), fixed, fixed_res);
   endtask

   // Holds the request side off until every outstanding result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_addrs.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input string text, input logic v6, input bit fixed,
                          input logic ok, input logic [63:0] hi, input logic [63:0] lo);
      directed_row_type row;
      row.text    = text;
      row.v6      = v6;
      row.fixed   = fixed;
      row.want.ok = ok;
      row.want.hi = hi;
      row.want.lo = lo;
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // Response side and checking.
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
      end
   endfunction

   // Each result transfer is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      parsed_addr_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_addrs.size() == 0) begin
            note_mismatch("result with nothing outstanding", '0, rsp_addr_low);
         end else begin
            want = expected_addrs.pop_front();
            if (rsp_ok !== want.ok) note_mismatch("ok", want.ok, rsp_ok);
            if (rsp_addr_high !== want.hi) note_mismatch("addr_high", want.hi, rsp_addr_high);
            if (rsp_addr_low !== want.lo) note_mismatch("addr_low", want.lo, rsp_addr_low);
         end
      end
   end

   // Watchdog: gives up after too long without any transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------

   initial begin
      char_q_type      chars;
      parsed_addr_type no_result;
      string           text;
      string           left;
      string           right;
      string           tok;
      logic            v6;
      logic [15:0]     grp_val;
      int unsigned     kind;
      int unsigned     target;
      int unsigned     words;
      int unsigned     n_hex;
      int unsigned     gap_at;
      int unsigned     pos;
      bit              with_gap;
      bit              with_tail;

      no_result = '0;
      clear_parser();

      // Directed strings; rows with an obvious answer carry it, the rest use the predictor.
      add_row("",                 1'b0, 1'b1, 1'b0, '0, '0);
      add_row("",                 1'b1, 1'b1, 1'b0, '0, '0);
      add_row("0.0.0.0",          1'b0, 1'b1, 1'b1, '0, '0);
      add_row("255.255.255.255",  1'b0, 1'b1, 1'b1, '0, 64'h0000_0000_FFFF_FFFF);
      add_row("000192.0168.00001.01", 1'b0, 1'b0, 1'b0, '0, '0);
      add_row("256.1.1.1",        1'b0, 1'b1, 1'b0, '0, '0);
      add_row("1.2.3",            1'b0, 1'b1, 1'b0, '0, '0);
      add_row("1.2.3.4.5",        1'b0, 1'b1, 1'b0, '0, '0);
      add_row("1.2\377\200.4",    1'b0, 1'b1, 1'b0, '0, '0);
      add_row("::",               1'b1, 1'b1, 1'b1, '0, '0);
      add_row("FFFF:ffff:FfFf:ffff:ffff:ffff:ffff:fffF", 1'b1, 1'b1, 1'b1, ALL_ONES, ALL_ONES);
      add_row(":1::",             1'b1, 1'b1, 1'b0, '0, '0);
      add_row("1:2:3:4:5:6:7:",   1'b1, 1'b1, 1'b0, '0, '0);
      add_row("1:2::",            1'b1, 1'b0, 1'b0, '0, '0);
      add_row("1::2::3",          1'b1, 1'b1, 1'b0, '0, '0);
      add_row("1:::2",            1'b1, 1'b1, 1'b0, '0, '0);
      add_row("1:2:3:4:5:6:7:8:9", 1'b1, 1'b1, 1'b0, '0, '0);
      add_row("1:2:3:4::5:6:7:8", 1'b1, 1'b1, 1'b0, '0, '0);
      add_row("::ffff:192.168.0.1", 1'b1, 1'b0, 1'b0, '0, '0);
      add_row("1:2:3:4:5:6:1.2.3.4", 1'b1, 1'b0, 1'b0, '0, '0);
      add_row("1:2:3:4:5:6:7:1.2.3.4", 1'b1, 1'b1, 1'b0, '0, '0);
      add_row("::12345.1.1.1",    1'b1, 1'b1, 1'b0, '0, '0);
      add_row("::a.1.2.3",        1'b1, 1'b1, 1'b0, '0, '0);
      add_row("::1.2.3.4:5",      1'b1, 1'b1, 1'b0, '0, '0);
      add_row("abcd:EF01:2345:6789:aBcD:ef01:2345:6789", 1'b1, 1'b0, 1'b0, '0, '0);

      // Reset is released at a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_text(text_chars(directed_rows[i].text), directed_rows[i].v6,
                   directed_rows[i].fixed, directed_rows[i].want);
      end
      drain_results();

      // Random strings in segments that cycle through four idling patterns, each
      // closed by a pause until the results are all back.
      for (int seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 85;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 85;
            end
            default: begin
               send_idle_pct = 6;
               stall_pct     = 6;
            end
         endcase
         target = chars_sent + 50;
         while (chars_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
               // Dotted quad, now and then sent with the other family.
               text = ipv4_text(5);
               v6   = ($urandom_range(9) == 0);
            end else begin
               // Hex groups with an optional gap and an optional dotted tail.
               with_gap  = ($urandom_range(2) != 0);
               with_tail = ($urandom_range(3) == 0);
               words     = with_gap ? $urandom_range(7, with_tail ? 2 : 0) : NUM_GROUPS;
               n_hex     = with_tail ? words - 2 : words;
               gap_at    = with_gap ? $urandom_range(n_hex, 0) : n_hex;
               left      = "";
               right     = "";
               for (int i = 0; i < n_hex; i++) begin
                  case ($urandom_range(3))
                     0: grp_val = 16'h0000;
                     1: grp_val = 16'hFFFF;
                     2: grp_val = 16'($urandom_range(15));
                     default: grp_val = 16'($urandom());
                  endcase
                  tok = $sformatf("%0h", grp_val);
                  while (tok.len() < 4 && $urandom_range(2) == 0) tok = {"0", tok};
                  if ($urandom_range(1)) tok = tok.toupper();
                  if (i < gap_at) left = (left.len() == 0) ? tok : {left, ":", tok};
                  else right = (right.len() == 0) ? tok : {right, ":", tok};
               end
               if (with_tail) begin
                  tok   = ipv4_text(4);
                  right = (right.len() == 0) ? tok : {right, ":", tok};
               end
               if (with_gap) text = {left, "::", right};
               else if (right.len() == 0) text = left;
               else if (left.len() == 0) text = right;
               else text = {left, ":", right};
               v6 = ($urandom_range(9) != 0);
            end
            chars = text_chars(text);

            if (kind >= 85) begin
               // Pure noise of up to ten characters.
               v6    = 1'($urandom_range(1));
               chars = {};
               repeat ($urandom_range(10)) chars.push_back(noise_char());
            end else if (kind % 4 == 0) begin
               // Break a well-formed string in one place.
               pos = (chars.size() == 0) ? 0 : $urandom_range(chars.size() - 1);
               case ($urandom_range(4))
                  0: begin
                     if (chars.size() != 0) chars[pos] = noise_char();
                  end
                  1: begin
                     if (chars.size() != 0) chars.delete(pos);
                  end
                  2: begin
                     chars.insert(pos, noise_char());
                  end
                  3: begin
                     chars.insert(pos, CHAR_COLON);
                  end
                  default: begin
                     while (chars.size() > pos) void'(chars.pop_back());
                  end
               endcase
            end
            send_text(chars, v6, 1'b0, no_result);
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_addrs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
